// ----- sv/ir_ac_frame_transmitter_core_assert.svh -----
// Assertion macros shared by the IR frame transmitter checkers.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef IR_AC_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define IR_AC_FRAME_TRANSMITTER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define IRAC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("irac assertion failed");

// next-cycle implication, off during reset
`define IRAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("irac assertion failed");

`endif

// ----- sv/irac_pkg.sv -----
// Types and constants of the IR air-conditioner frame transmitter.
// No dependencies; imported by every module of the block.
package irac_pkg;

	localparam int FRAME_BYTES = 15;
	localparam int TOTAL_BITS  = FRAME_BYTES * 8 + 1;
	localparam int BITPOS_W    = $clog2(TOTAL_BITS);
	localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
	localparam int TICK_W      = 15;
	localparam int CODE_W      = 4;
	localparam int CFG_INDEX_W = 3;

	// fixed frame bytes
	localparam logic [7:0] B0_PREAMBLE = 8'h6A;
	localparam logic [7:0] B5_OFF      = 8'h03;
	localparam logic [7:0] B5_BASE     = 8'h40;
	localparam logic [7:0] B8_CONST    = 8'h30;
	localparam logic [7:0] B10_BASE    = 8'h30;

	// register reset values
	localparam logic [TICK_W-1:0] HDR_MARK_RST   = 15'd800;
	localparam logic [TICK_W-1:0] HDR_SPACE_RST  = 15'd18000;
	localparam logic [TICK_W-1:0] BIT_MARK_RST   = 15'd560;
	localparam logic [TICK_W-1:0] ONE_SPACE_RST  = 15'd1500;
	localparam logic [TICK_W-1:0] ZERO_SPACE_RST = 15'd480;
	localparam logic [CODE_W-1:0] OFF_MODE_RST   = 4'd0;
	localparam logic [CODE_W-1:0] COOL_MODE_RST  = 4'd1;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_COMMAND = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HDR_MARK   = 3'd0,
		CFG_HDR_SPACE  = 3'd1,
		CFG_BIT_MARK   = 3'd2,
		CFG_ONE_SPACE  = 3'd3,
		CFG_ZERO_SPACE = 3'd4,
		CFG_OFF_MODE   = 3'd5,
		CFG_COOL_MODE  = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HMARK  = 3'd1,
		PH_HSPACE = 3'd2,
		PH_BMARK  = 3'd3,
		PH_BSPACE = 3'd4
	} phase_t;

	typedef struct packed {
		op_t        operation;
		logic [3:0] mode;
		logic [3:0] fan;
		logic [7:0] temperature;
		logic [3:0] turbo;
		logic [2:0] swing;
		logic       sheet;
	} cmd_item_t;

	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic command_taken;
	} res_item_t;

	typedef struct packed {
		logic [TICK_W-1:0] hdr_mark;
		logic [TICK_W-1:0] hdr_space;
		logic [TICK_W-1:0] bit_mark;
		logic [TICK_W-1:0] one_space;
		logic [TICK_W-1:0] zero_space;
	} timing_t;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

endpackage

// ----- sv/irac_frame_build.sv -----
// Frame assembly and checksum for one command beat.
// Depends on irac_pkg.
module irac_frame_build
	import irac_pkg::*;
(
	input  cmd_item_t         cmd,
	input  logic [CODE_W-1:0] off_mode,
	input  logic [CODE_W-1:0] cool_mode,
	output frame_t            frame
);

	function automatic logic [3:0] rev4(input logic [3:0] n);
		return {n[0], n[1], n[2], n[3]};
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] b);
		return {rev4(b[3:0]), rev4(b[7:4])};
	endfunction

	// contribution of the nibbles that never change
	localparam logic [7:0] FIXED_SUM = 8'({4'd0, rev4(B0_PREAMBLE[7:4])}
		+ {4'd0, rev4(B0_PREAMBLE[3:0])} + {4'd0, rev4(B8_CONST[7:4])}
		+ {4'd0, rev4(B8_CONST[3:0])} + {4'd0, rev4(B10_BASE[7:4])});

	logic       sheet_eff;
	logic [7:0] b5;
	logic [7:0] sum;

	always_comb begin
		sheet_eff = cmd.sheet & (cmd.mode == cool_mode);
		if (cmd.mode == off_mode) begin
			b5 = B5_OFF;
		end else begin
			b5 = B5_BASE | {sheet_eff, 1'b0, cmd.swing, 3'b000};
		end
		sum = FIXED_SUM + {4'd0, rev4(cmd.temperature[3:0])}
			+ {4'd0, rev4(cmd.temperature[7:4])}
			+ {4'd0, rev4(cmd.mode)} + {4'd0, rev4(cmd.fan)}
			+ {4'd0, rev4(b5[3:0])} + {4'd0, rev4(b5[7:4])}
			+ {4'd0, rev4(cmd.turbo)};

		frame     = '0;
		frame[0]  = B0_PREAMBLE;
		frame[1]  = cmd.temperature;
		frame[4]  = {cmd.fan, cmd.mode};
		frame[5]  = b5;
		frame[8]  = B8_CONST;
		frame[10] = B10_BASE | {4'd0, cmd.turbo};
		frame[FRAME_BYTES-1] = rev8(sum);
	end

endmodule

// ----- sv/irac_pulse_seq.sv -----
// Pulse-distance sequencer: phase, segment timer, bit pointer and frame store.
// Depends on irac_pkg; the frame comes from irac_frame_build.
module irac_pulse_seq
	import irac_pkg::*;
#(
	parameter int TIMER_BITS = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  op_t       operation,
	input  frame_t    frame,
	input  timing_t   timing,
	output res_item_t res_next
);

	phase_t                phase_q, phase_d;
	logic [TIMER_BITS-1:0] count_q, count_d;
	logic [BITPOS_W-1:0]   bitpos_q, bitpos_d;
	logic                  level_q, level_d;
	frame_t                frame_q;

	logic                  load;
	logic                  cur_bit;
	logic [BYTE_IDX_W-1:0] byte_sel;
	logic                  past_data;
	logic [TICK_W-1:0]     seg_raw;
	logic [TICK_W-1:0]     seg_len;
	logic [TIMER_BITS-1:0] count_inc;
	logic                  seg_end;

	always_comb begin
		past_data = (bitpos_q >= BITPOS_W'(FRAME_BYTES * 8));
		byte_sel  = past_data ? '0 : bitpos_q[BITPOS_W-1:3];
		cur_bit   = past_data | frame_q[byte_sel][~bitpos_q[2:0]];

		case (phase_q)
			PH_HMARK:  seg_raw = timing.hdr_mark;
			PH_HSPACE: seg_raw = timing.hdr_space;
			PH_BMARK:  seg_raw = timing.bit_mark;
			PH_BSPACE: seg_raw = cur_bit ? timing.one_space : timing.zero_space;
			default:   seg_raw = TICK_W'(1);
		endcase
		// zero length counts as one tick
		seg_len   = (seg_raw == '0) ? TICK_W'(1) : seg_raw;
		count_inc = count_q + 1'b1;
		seg_end   = (count_inc >= TIMER_BITS'(seg_len));

		load     = fire && (operation == OP_COMMAND) && (phase_q == PH_IDLE);
		phase_d  = phase_q;
		count_d  = count_q;
		bitpos_d = bitpos_q;
		level_d  = level_q;

		if (load) begin
			phase_d  = PH_HMARK;
			count_d  = '0;
			bitpos_d = '0;
			level_d  = 1'b0;
		end else if (fire && (operation == OP_TICK) && (phase_q != PH_IDLE)) begin
			if (!seg_end) begin
				count_d = count_inc;
			end else begin
				count_d = '0;
				case (phase_q)
					PH_HMARK: begin
						phase_d = PH_HSPACE;
						level_d = 1'b1;
					end
					PH_HSPACE: begin
						phase_d  = PH_BMARK;
						bitpos_d = '0;
						level_d  = 1'b0;
					end
					PH_BMARK: begin
						phase_d = PH_BSPACE;
						level_d = 1'b1;
					end
					PH_BSPACE: begin
						if (bitpos_q == BITPOS_W'(TOTAL_BITS - 1)) begin
							phase_d  = PH_IDLE;
							bitpos_d = '0;
							level_d  = 1'b1;
						end else begin
							phase_d  = PH_BMARK;
							bitpos_d = bitpos_q + 1'b1;
							level_d  = 1'b0;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						level_d = 1'b1;
					end
				endcase
			end
		end

		res_next.ir_level      = level_d;
		res_next.busy_res      = (phase_d != PH_IDLE);
		res_next.command_taken = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			bitpos_q <= '0;
			level_q  <= 1'b1;
		end else begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			bitpos_q <= bitpos_d;
			level_q  <= level_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
	end

endmodule

// ----- sv/ir_ac_frame_transmitter_core.sv -----
// IR air-conditioner frame transmitter, top level.
// Depends on irac_pkg, irac_frame_build and irac_pulse_seq.
//
// Takes one beat per clock on cmd: a command beat builds the 15-byte frame
// (checksum in the last byte) and starts the header mark, a tick beat moves
// the pulse timer by one. Every beat yields one res beat with the line level,
// a busy flag and whether a command was taken; a beat passes through the input
// register, then through the frame/timer logic into the result register, and
// throughput is one beat per cycle as long as res is not stalled.
// A command while a frame is in flight is dropped. Segment lengths and mode
// codes sit in seven registers on the cfg port, to be written while idle.
module ir_ac_frame_transmitter_core
	import irac_pkg::*;
#(
	parameter int TIMER_BITS = 15
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  cmd_item_t              cmd,
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_item_t              res,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]      cfg_data
);

	timing_t           timing_q;
	logic [CODE_W-1:0] off_mode_q;
	logic [CODE_W-1:0] cool_mode_q;

	logic      cmd_valid_s1;
	cmd_item_t cmd_s1;
	logic      res_valid_q;
	res_item_t res_q;

	logic      res_free;
	logic      fire;
	frame_t    frame;
	res_item_t res_next;

	assign cfg_ready = 1'b1;
	assign res_free  = !res_valid_q || !res_stall;
	assign fire      = cmd_valid_s1 && res_free;
	assign cmd_stall = cmd_valid_s1 && !res_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.hdr_mark   <= HDR_MARK_RST;
			timing_q.hdr_space  <= HDR_SPACE_RST;
			timing_q.bit_mark   <= BIT_MARK_RST;
			timing_q.one_space  <= ONE_SPACE_RST;
			timing_q.zero_space <= ZERO_SPACE_RST;
			off_mode_q          <= OFF_MODE_RST;
			cool_mode_q         <= COOL_MODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HDR_MARK:   timing_q.hdr_mark   <= cfg_data;
				CFG_HDR_SPACE:  timing_q.hdr_space  <= cfg_data;
				CFG_BIT_MARK:   timing_q.bit_mark   <= cfg_data;
				CFG_ONE_SPACE:  timing_q.one_space  <= cfg_data;
				CFG_ZERO_SPACE: timing_q.zero_space <= cfg_data;
				CFG_OFF_MODE:   off_mode_q          <= cfg_data[CODE_W-1:0];
				CFG_COOL_MODE:  cool_mode_q         <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register and result register handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				cmd_valid_s1 <= 1'b1;
			end else if (fire) begin
				cmd_valid_s1 <= 1'b0;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (fire) begin
			res_q <= res_next;
		end
	end

	irac_frame_build u_build (
		.cmd       (cmd_s1),
		.off_mode  (off_mode_q),
		.cool_mode (cool_mode_q),
		.frame     (frame)
	);

	irac_pulse_seq #(
		.TIMER_BITS (TIMER_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.operation (cmd_s1.operation),
		.frame     (frame),
		.timing    (timing_q),
		.res_next  (res_next)
	);

endmodule

// ----- sv/irac_checker.sv -----
// Port-level checks for the IR frame transmitter, bound to the top level.
// Depends on irac_pkg and ir_ac_frame_transmitter_core_assert.svh.
`include "ir_ac_frame_transmitter_core_assert.svh"

module irac_checker
	import irac_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res
);

	// a stalled result beat holds
	`IRAC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

	// a taken command starts a frame with the header mark
	`IRAC_ASSERT_NOW(a_taken_mark, res_valid && res.command_taken,
		res.busy_res && !res.ir_level)

	// the line rests high whenever no frame is in flight
	`IRAC_ASSERT_NOW(a_idle_high, res_valid && !res.busy_res, res.ir_level)

endmodule

bind ir_ac_frame_transmitter_core irac_checker u_irac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ----- verif/ir_ac_frame_transmitter_core_tb.sv -----
// Testbench for the IR air-conditioner frame transmitter core.
// Needs irac_pkg and ir_ac_frame_transmitter_core; predicts every res beat from
// the accepted cmd beats and the register writes, and checks them in order.
module ir_ac_frame_transmitter_core_tb;
	import irac_pkg::*;

	localparam int ITEMS_PER_PHASE = 70;
	localparam int RAND_PHASES     = 6;
	localparam int HOLD_CYCLES     = 400;
	localparam int TICK_MAX        = 32767;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	// Tracks line level and frame progress, holds the res beats still owed.
	class ir_frame_tracker;
		timing_t           timing;
		logic [CODE_W-1:0] off_code;
		logic [CODE_W-1:0] cool_code;
		phase_t            phase;
		logic [TICK_W-1:0] count;
		frame_t            frame;
		int                bit_pos;
		logic              level;
		res_item_t         line_q[$];
		int                errors;
		int                beats_seen;

		function new();
			timing.hdr_mark   = HDR_MARK_RST;
			timing.hdr_space  = HDR_SPACE_RST;
			timing.bit_mark   = BIT_MARK_RST;
			timing.one_space  = ONE_SPACE_RST;
			timing.zero_space = ZERO_SPACE_RST;
			off_code   = OFF_MODE_RST;
			cool_code  = COOL_MODE_RST;
			phase      = PH_IDLE;
			count      = '0;
			frame      = '0;
			bit_pos    = 0;
			level      = 1'b1;
			errors     = 0;
			beats_seen = 0;
		endfunction

		function logic [3:0] rev4(logic [3:0] n);
			return {n[0], n[1], n[2], n[3]};
		endfunction

		function void build_frame(cmd_item_t c);
			logic [7:0] csum;
			logic       sheet_bit;
			frame    = '0;
			frame[0] = B0_PREAMBLE;
			frame[1] = c.temperature;
			frame[4] = {c.fan, c.mode};
			if (c.mode == off_code) begin
				frame[5] = B5_OFF;
			end else begin
				// sheet only survives in cool mode
				sheet_bit = (c.mode == cool_code) ? c.sheet : 1'b0;
				frame[5]  = B5_BASE | {sheet_bit, 1'b0, c.swing, 3'b000};
			end
			frame[8]  = B8_CONST;
			frame[10] = B10_BASE | {4'h0, c.turbo};
			csum = 8'h00;
			for (int i = 0; i < FRAME_BYTES - 1; i++)
				csum = csum + rev4(frame[i][3:0]) + rev4(frame[i][7:4]);
			frame[FRAME_BYTES-1] = {rev4(csum[3:0]), rev4(csum[7:4])};
		endfunction

		function logic current_bit();
			// the closing bit past the last byte is always a one
			if (bit_pos >= FRAME_BYTES * 8)
				return 1'b1;
			return frame[bit_pos / 8][7 - (bit_pos % 8)];
		endfunction

		function logic [TICK_W-1:0] seg_len();
			logic [TICK_W-1:0] len;
			case (phase)
				PH_HMARK:  len = timing.hdr_mark;
				PH_HSPACE: len = timing.hdr_space;
				PH_BMARK:  len = timing.bit_mark;
				PH_BSPACE: len = current_bit() ? timing.one_space : timing.zero_space;
				default:   len = TICK_W'(1);
			endcase
			return (len == '0) ? TICK_W'(1) : len;
		endfunction

		function void step_timer();
			count = count + 1'b1;
			if (count < seg_len())
				return;
			count = '0;
			case (phase)
				PH_HMARK: begin
					phase = PH_HSPACE;
					level = 1'b1;
				end
				PH_HSPACE: begin
					phase   = PH_BMARK;
					bit_pos = 0;
					level   = 1'b0;
				end
				PH_BMARK: begin
					phase = PH_BSPACE;
					level = 1'b1;
				end
				PH_BSPACE: begin
					if (bit_pos + 1 >= TOTAL_BITS) begin
						phase   = PH_IDLE;
						bit_pos = 0;
						level   = 1'b1;
					end else begin
						bit_pos++;
						phase = PH_BMARK;
						level = 1'b0;
					end
				end
				default: begin
					phase = PH_IDLE;
					level = 1'b1;
				end
			endcase
		endfunction

		function void set_reg(cfg_reg_t idx, logic [TICK_W-1:0] data);
			case (idx)
				CFG_HDR_MARK:   timing.hdr_mark   = data;
				CFG_HDR_SPACE:  timing.hdr_space  = data;
				CFG_BIT_MARK:   timing.bit_mark   = data;
				CFG_ONE_SPACE:  timing.one_space  = data;
				CFG_ZERO_SPACE: timing.zero_space = data;
				CFG_OFF_MODE:   off_code  = data[CODE_W-1:0];
				CFG_COOL_MODE:  cool_code = data[CODE_W-1:0];
				default: ;
			endcase
		endfunction

		// Returns 1 when the beat did something: a command from idle or a tick mid-frame.
		function bit take_beat(cmd_item_t c);
			bit        acted;
			res_item_t r;
			acted           = 1'b0;
			r.command_taken = 1'b0;
			if (c.operation == OP_COMMAND) begin
				if (phase == PH_IDLE) begin
					build_frame(c);
					phase           = PH_HMARK;
					count           = '0;
					bit_pos         = 0;
					level           = 1'b0;
					r.command_taken = 1'b1;
					acted           = 1'b1;
				end
			end else if (phase != PH_IDLE) begin
				step_timer();
				acted = 1'b1;
			end
			r.ir_level = level;
			r.busy_res = (phase != PH_IDLE);
			line_q.push_back(r);
			return acted;
		endfunction

		task report(string what);
			$display("ir_ac_frame_transmitter_core_tb: mismatch at res beat %0d: %s",
				beats_seen, what);
			errors++;
		endtask

		task check_beat(res_item_t got);
			res_item_t want;
			beats_seen++;
			if (line_q.size() == 0) begin
				report("res beat with nothing expected");
				return;
			end
			want = line_q.pop_front();
			if (got.ir_level !== want.ir_level)
				report($sformatf("ir_level %b, expected %b", got.ir_level, want.ir_level));
			if (got.busy_res !== want.busy_res)
				report($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
			if (got.command_taken !== want.command_taken)
				report($sformatf("command_taken %b, expected %b",
					got.command_taken, want.command_taken));
		endtask

		function int pending();
			return line_q.size();
		endfunction

		function bit busy();
			return phase != PH_IDLE;
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cmd_valid = 1'b0;
	logic                   cmd_stall;
	cmd_item_t              cmd       = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	res_item_t              res;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]      cfg_data  = '0;

	ir_frame_tracker tracker;

	int           hold_reqs    = 0;
	int           hold_seen    = 0;
	int           hold_left    = 0;
	int           stretch_left = 0;
	stall_style_t stall_style  = STALL_NONE;

	ir_ac_frame_transmitter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("ir_ac_frame_transmitter_core_tb: done, errors");
		$finish;
	end

	// Receiver: a long hold-off on request, otherwise stretches of varying stall.
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			if (stretch_left == 0) begin
				stall_style  = stall_style_t'($urandom_range(0, 3));
				stretch_left = $urandom_range(16, 96);
			end
			stretch_left--;
			case (stall_style)
				STALL_NONE:  res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
				default:     res_stall <= (stretch_left % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_beat(res);
	end

	task send_item(cmd_item_t it, output bit acted);
		cmd_valid <= 1'b1;
		cmd       <= it;
		do @(posedge clk); while (cmd_stall);
		acted = tracker.take_beat(it);
	endtask

	task idle_cycles(int n);
		cmd_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop valid and hold until every owed res beat is back.
	task settle();
		cmd_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(cfg_reg_t idx, logic [TICK_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task program_regs(logic [TICK_W-1:0] hm, logic [TICK_W-1:0] hs, logic [TICK_W-1:0] bm,
			logic [TICK_W-1:0] os, logic [TICK_W-1:0] zs,
			logic [CODE_W-1:0] off, logic [CODE_W-1:0] cool);
		write_reg(CFG_HDR_MARK, hm);
		write_reg(CFG_HDR_SPACE, hs);
		write_reg(CFG_BIT_MARK, bm);
		write_reg(CFG_ONE_SPACE, os);
		write_reg(CFG_ZERO_SPACE, zs);
		write_reg(CFG_OFF_MODE, TICK_W'(off));
		write_reg(CFG_COOL_MODE, TICK_W'(cool));
	endtask

	function cmd_item_t cmd_of(logic [3:0] mode, logic [3:0] fan, logic [7:0] temp,
			logic [3:0] turbo, logic [2:0] swing, logic sheet);
		cmd_item_t c;
		c.operation   = OP_COMMAND;
		c.mode        = mode;
		c.fan         = fan;
		c.temperature = temp;
		c.turbo       = turbo;
		c.swing       = swing;
		c.sheet       = sheet;
		return c;
	endfunction

	function cmd_item_t tick_of();
		cmd_item_t c;
		c           = cmd_of(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
			3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		c.operation = OP_TICK;
		return c;
	endfunction

	// Commands mostly when idle, so frames start soon and ticks carry them through.
	function cmd_item_t random_item();
		cmd_item_t c;
		int        pick;
		c    = tick_of();
		pick = $urandom_range(0, 99);
		if (tracker.busy() ? (pick < 3) : (pick < 70))
			c.operation = OP_COMMAND;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			c.mode = tracker.off_code;
		else if (pick < 6)
			c.mode = tracker.cool_code;
		return c;
	endfunction

	task run_to_idle();
		bit acted;
		while (tracker.busy())
			send_item(tick_of(), acted);
	endtask

	task run_random(int target);
		int done;
		int burst;
		bit acted;
		done = 0;
		while (done < target) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && done < target) begin
				send_item(random_item(), acted);
				if (acted)
					done++;
				burst--;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 6));
		end
	endtask

	initial begin
		bit acted;
		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: idle tick, command at the field extremes with mode off,
		// a few ticks, then a command while busy
		send_item(tick_of(), acted);
		send_item(cmd_of(4'd0, 4'hF, 8'hFF, 4'hF, 3'd7, 1'b1), acted);
		repeat (5) send_item(tick_of(), acted);
		send_item(cmd_of(4'd1, 4'd1, 8'd1, 4'd1, 3'd1, 1'b1), acted);
		settle();
		// zero lengths mid-frame: count is already past, segment ends on next tick
		program_regs(0, 0, 0, 0, 0, 4'd0, 4'd1);
		run_to_idle();
		send_item(cmd_of(4'd1, 4'd0, 8'd0, 4'd0, 3'd7, 1'b1), acted);
		run_to_idle();
		send_item(cmd_of(4'd15, 4'd8, 8'h80, 4'd8, 3'd4, 1'b1), acted);
		run_to_idle();
		send_item(cmd_of(4'd2, 4'd0, 8'd0, 4'd0, 3'd0, 1'b0), acted);
		run_to_idle();

		// longest header, cut short mid-segment
		settle();
		write_reg(CFG_HDR_MARK, TICK_W'(TICK_MAX));
		write_reg(CFG_HDR_SPACE, TICK_W'(TICK_MAX));
		send_item(cmd_of(4'd1, 4'd3, 8'd24, 4'd2, 3'd5, 1'b1), acted);
		repeat (20) send_item(tick_of(), acted);
		settle();
		write_reg(CFG_HDR_MARK, 2);
		repeat (10) send_item(tick_of(), acted);
		settle();
		write_reg(CFG_HDR_SPACE, 3);
		run_to_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case (p)
				0: program_regs(0, 0, 0, 0, 0, 4'd0, 4'd1);
				1: program_regs(0, 0, 0, 0, 0, 4'd15, 4'd15);
				2: program_regs(TICK_W'($urandom_range(0, 1)), TICK_W'($urandom_range(0, 1)),
					TICK_W'($urandom_range(0, 1)), TICK_W'($urandom_range(0, 1)),
					TICK_W'($urandom_range(0, 1)), 4'd15, 4'd0);
				3: program_regs(TICK_W'($urandom_range(0, 1)), TICK_W'($urandom_range(0, 1)),
					TICK_W'($urandom_range(0, 1)), TICK_W'($urandom_range(0, 1)),
					TICK_W'($urandom_range(2, 12)),
					CODE_W'($urandom_range(0, 15)), CODE_W'($urandom_range(0, 15)));
				4: program_regs(TICK_W'($urandom_range(0, 2)), TICK_W'($urandom_range(0, 2)),
					TICK_W'($urandom_range(0, 2)), TICK_W'($urandom_range(0, 2)),
					TICK_W'($urandom_range(0, 2)),
					CODE_W'($urandom_range(0, 15)), CODE_W'($urandom_range(0, 15)));
				default: program_regs(0, 0, 0, 1, 0, 4'd0, 4'd1);
			endcase
			// stall the receiver long enough to back the block up into cmd
			if (p == 1 || p == 4)
				hold_reqs++;
			run_random(ITEMS_PER_PHASE / 2);
			settle();
			run_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
		end

		settle();
		repeat (16) @(posedge clk);
		if (tracker.errors == 0)
			$display("ir_ac_frame_transmitter_core_tb: done, clean");
		else
			$display("ir_ac_frame_transmitter_core_tb: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/irac_pkg.sv
sv/irac_frame_build.sv
sv/irac_pulse_seq.sv
sv/ir_ac_frame_transmitter_core.sv
sv/irac_checker.sv
verif/ir_ac_frame_transmitter_core_tb.sv
